// ===== hw/rtl/pll_pkg.sv =====
package pll_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WEIGHT_W   = 17;
  localparam int PROD_W     = SAMPLE_W + WEIGHT_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int CFG_W      = WEIGHT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int DEF_TABLE_DEPTH = 65536;
  localparam int ROUND_HALF = 32768;

  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_FIRST  = WEIGHT_W'(4732);
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_SECOND = WEIGHT_W'(46871);
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_THIRD  = WEIGHT_W'(13933);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_ENABLE  = 3'd0,
    REG_WIDE_SAMPLES  = 3'd1,
    REG_COLOR_INPUT   = 3'd2,
    REG_WEIGHT_FIRST  = 3'd3,
    REG_WEIGHT_SECOND = 3'd4,
    REG_WEIGHT_THIRD  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                en;
    logic [SAMPLE_W-1:0] addr;
    logic [SAMPLE_W-1:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic table_en;
    logic wide;
    logic rd_en;
    logic adv2;
  } lane_ctl_t;

endpackage

// ===== hw/rtl/pll_if.sv =====
interface pll_in_if;
  import pll_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [SAMPLE_W-1:0] first_sample;
  logic [SAMPLE_W-1:0] second_sample;
  logic [SAMPLE_W-1:0] third_sample;
  logic [SAMPLE_W-1:0] table_index;
  logic [SAMPLE_W-1:0] table_value;

  modport source (output valid, mode, first_sample, second_sample, third_sample,
                  table_index, table_value, input ready);
  modport sink (input valid, mode, first_sample, second_sample, third_sample,
                table_index, table_value, output ready);
endinterface

interface pll_out_if;
  import pll_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] luma;
  logic [SAMPLE_W-1:0] linear_first;
  logic [SAMPLE_W-1:0] linear_second;
  logic [SAMPLE_W-1:0] linear_third;
  logic                luma_saturated;

  modport source (output valid, luma, linear_first, linear_second, linear_third,
                  luma_saturated, input ready);
  modport sink (input valid, luma, linear_first, linear_second, linear_third,
                luma_saturated, output ready);
endinterface

// ===== hw/rtl/pll_lane.sv =====
module pll_lane #(
  parameter int TABLE_DEPTH = pll_pkg::DEF_TABLE_DEPTH
) (
  input  logic                                clk,
  input  logic [pll_pkg::SAMPLE_W-1:0]        sample,
  input  pll_pkg::tbl_wr_t                    wr,
  input  pll_pkg::lane_ctl_t                  ctl,
  input  logic [pll_pkg::WEIGHT_W-1:0]        weight,
  output logic [pll_pkg::SAMPLE_W-1:0]        lin,
  output logic [pll_pkg::PROD_W-1:0]          prod
);
  import pll_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  if ((TABLE_DEPTH & (TABLE_DEPTH - 1)) != 0) begin : g_depth_check
    $error("TABLE_DEPTH must be a power of two");
  end

  logic [SAMPLE_W-1:0] mem [TABLE_DEPTH];
  logic [SAMPLE_W-1:0] raw;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] byp;
  logic [SAMPLE_W-1:0] lin_c;

  // Narrow samples keep their low byte, moved to the top.
  assign raw = ctl.wide ? sample : {sample[7:0], 8'h00};

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[raw[AW-1:0]];
      byp     <= raw;
    end
  end

  assign lin_c = ctl.table_en ? rd_data : byp;

  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      lin  <= lin_c;
      prod <= PROD_W'(weight) * PROD_W'(lin_c);
    end
  end

endmodule

// ===== hw/rtl/pll_merge.sv =====
module pll_merge (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          color,
  input  logic [pll_pkg::PROD_W-1:0]    prod_first,
  input  logic [pll_pkg::PROD_W-1:0]    prod_second,
  input  logic [pll_pkg::PROD_W-1:0]    prod_third,
  input  logic [pll_pkg::SAMPLE_W-1:0]  lin_first,
  input  logic [pll_pkg::SAMPLE_W-1:0]  lin_second,
  input  logic [pll_pkg::SAMPLE_W-1:0]  lin_third,
  output logic [pll_pkg::SAMPLE_W-1:0]  luma,
  output logic [pll_pkg::SAMPLE_W-1:0]  linear_first,
  output logic [pll_pkg::SAMPLE_W-1:0]  linear_second,
  output logic [pll_pkg::SAMPLE_W-1:0]  linear_third,
  output logic                          luma_saturated
);
  import pll_pkg::*;

  logic [SUM_W-1:0]    sum;
  logic                over;
  logic [SAMPLE_W-1:0] luma_c;

  assign sum = SUM_W'(prod_first) + SUM_W'(prod_second) + SUM_W'(prod_third)
             + SUM_W'(ROUND_HALF);
  assign over   = |sum[SUM_W-1:SAMPLE_W+16];
  assign luma_c = over ? '1 : sum[SAMPLE_W+15:16];

  always_ff @(posedge clk) begin
    if (en) begin
      linear_first <= lin_first;
      if (color) begin
        luma           <= luma_c;
        luma_saturated <= over;
        linear_second  <= lin_second;
        linear_third   <= lin_third;
      end else begin
        // gray: replicate the one channel
        luma           <= lin_first;
        luma_saturated <= 1'b0;
        linear_second  <= lin_first;
        linear_third   <= lin_first;
      end
    end
  end

endmodule

// ===== hw/rtl/pixel_linearize_and_luma.sv =====
// Pixel linearization and luma.
//
// pix_in carries one item per transfer. mode 0 is a pixel: three samples
// (blue, green, red) or one gray sample in first_sample. mode 1 writes one
// transfer table entry and produces nothing on pix_out.
// pix_out carries the three linear channels and the rounded, clamped luma
// with its saturation flag, one transfer per pixel, in input order.
// Configuration is written through cfg_wr_en / cfg_index / cfg_data while
// no pixel is in flight.
// A pixel accepted on pix_in passes the table read, lane multiply and merge
// registers before it appears on pix_out. Throughput is one item per cycle
// while pix_out is not stalled; each lane owns a copy of the table, so the
// three lookups of a pixel run side by side on one read port each.
// Reset clears the pipeline and loads register defaults; table contents are
// undefined until written. When pix_out stalls, each stage holds and
// bubbles are squeezed out before pix_in.ready drops.
module pixel_linearize_and_luma #(
  parameter int TABLE_DEPTH = pll_pkg::DEF_TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  pll_in_if.sink                        pix_in,
  pll_out_if.source                     pix_out,
  input  logic                          cfg_wr_en,
  input  logic [pll_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pll_pkg::CFG_W-1:0]     cfg_data
);
  import pll_pkg::*;

  logic                table_enable;
  logic                wide_samples;
  logic                color_input;
  logic [WEIGHT_W-1:0] weight_first;
  logic [WEIGHT_W-1:0] weight_second;
  logic [WEIGHT_W-1:0] weight_third;

  logic v1, v2, out_valid;
  logic adv1, adv2, adv3;
  logic in_xfer;

  tbl_wr_t   wr;
  lane_ctl_t ctl;

  logic [SAMPLE_W-1:0] lin_f, lin_s, lin_t;
  logic [PROD_W-1:0]   prod_f, prod_s, prod_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_enable  <= 1'b0;
      wide_samples  <= 1'b0;
      color_input   <= 1'b1;
      weight_first  <= RST_WEIGHT_FIRST;
      weight_second <= RST_WEIGHT_SECOND;
      weight_third  <= RST_WEIGHT_THIRD;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_TABLE_ENABLE:  table_enable  <= cfg_data[0];
        REG_WIDE_SAMPLES:  wide_samples  <= cfg_data[0];
        REG_COLOR_INPUT:   color_input   <= cfg_data[0];
        REG_WEIGHT_FIRST:  weight_first  <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_SECOND: weight_second <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_THIRD:  weight_third  <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage advances when it is empty or the next one advances.
  assign adv3 = !out_valid || pix_out.ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign pix_in.ready = adv1;
  assign in_xfer = pix_in.valid && pix_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= pix_in.valid && !pix_in.mode;
      if (adv2) v2 <= v1;
      if (adv3) out_valid <= v2;
    end
  end

  assign wr.en        = in_xfer && pix_in.mode;
  assign wr.addr      = pix_in.table_index;
  assign wr.data      = pix_in.table_value;
  assign ctl.table_en = table_enable;
  assign ctl.wide     = wide_samples;
  assign ctl.rd_en    = adv1;
  assign ctl.adv2     = adv2;

  pll_lane #(.TABLE_DEPTH(TABLE_DEPTH)) u_lane_first (
    .clk(clk), .sample(pix_in.first_sample), .wr(wr), .ctl(ctl),
    .weight(weight_first), .lin(lin_f), .prod(prod_f)
  );

  pll_lane #(.TABLE_DEPTH(TABLE_DEPTH)) u_lane_second (
    .clk(clk), .sample(pix_in.second_sample), .wr(wr), .ctl(ctl),
    .weight(weight_second), .lin(lin_s), .prod(prod_s)
  );

  pll_lane #(.TABLE_DEPTH(TABLE_DEPTH)) u_lane_third (
    .clk(clk), .sample(pix_in.third_sample), .wr(wr), .ctl(ctl),
    .weight(weight_third), .lin(lin_t), .prod(prod_t)
  );

  pll_merge u_merge (
    .clk(clk), .en(adv3), .color(color_input),
    .prod_first(prod_f), .prod_second(prod_s), .prod_third(prod_t),
    .lin_first(lin_f), .lin_second(lin_s), .lin_third(lin_t),
    .luma(pix_out.luma), .linear_first(pix_out.linear_first),
    .linear_second(pix_out.linear_second), .linear_third(pix_out.linear_third),
    .luma_saturated(pix_out.luma_saturated)
  );

  assign pix_out.valid = out_valid;

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    in_xfer && pix_in.mode |=> !v1)
    else $error("table write entered the pixel pipeline");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !adv3 |=> v2)
    else $error("stage two dropped an item under stall");

  a_sat_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && pix_out.luma_saturated |-> pix_out.luma == '1)
    else $error("saturated luma not clamped");

  a_gray_replicate: assert property (@(posedge clk) disable iff (rst)
    out_valid && !color_input |->
      pix_out.luma == pix_out.linear_first && !pix_out.luma_saturated &&
      pix_out.linear_second == pix_out.linear_first)
    else $error("gray output not replicated");

endmodule

// ===== tb/pixel_linearize_and_luma_tb.sv =====
`timescale 1ns / 1ps

module pixel_linearize_and_luma_tb;
  import pll_pkg::*;

  localparam int TBL_DEPTH = DEF_TABLE_DEPTH;
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_TABLE_WRITE = 1'b1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_SLACK = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic                mode;
    logic [SAMPLE_W-1:0] first_sample;
    logic [SAMPLE_W-1:0] second_sample;
    logic [SAMPLE_W-1:0] third_sample;
    logic [SAMPLE_W-1:0] table_index;
    logic [SAMPLE_W-1:0] table_value;
  } pix_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] luma;
    logic [SAMPLE_W-1:0] lin_first;
    logic [SAMPLE_W-1:0] lin_second;
    logic [SAMPLE_W-1:0] lin_third;
    logic                sat;
  } luma_result_t;

  class luma_scoreboard;
    logic                table_on;
    logic                wide;
    logic                color;
    logic [WEIGHT_W-1:0] w_first;
    logic [WEIGHT_W-1:0] w_second;
    logic [WEIGHT_W-1:0] w_third;
    logic [SAMPLE_W-1:0] lut [TBL_DEPTH];
    luma_result_t        results_due[$];
    int                  mismatches;
    int                  pixels;
    int                  gray_pixels;
    int                  saturated;
    int                  table_writes;

    function new();
      table_on = 1'b0;
      wide = 1'b0;
      color = 1'b1;
      w_first = RST_WEIGHT_FIRST;
      w_second = RST_WEIGHT_SECOND;
      w_third = RST_WEIGHT_THIRD;
      mismatches = 0;
      pixels = 0;
      gray_pixels = 0;
      saturated = 0;
      table_writes = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_TABLE_ENABLE:  table_on = value[0];
        REG_WIDE_SAMPLES:  wide = value[0];
        REG_COLOR_INPUT:   color = value[0];
        REG_WEIGHT_FIRST:  w_first = value;
        REG_WEIGHT_SECOND: w_second = value;
        REG_WEIGHT_THIRD:  w_third = value;
        default: ;
      endcase
    endfunction

    function logic [SAMPLE_W-1:0] linearize(logic [SAMPLE_W-1:0] raw);
      logic [SAMPLE_W-1:0] v;
      v = wide ? raw : {raw[7:0], 8'h00};
      if (table_on) v = lut[v % TBL_DEPTH];
      return v;
    endfunction

    function void note_item(pix_item_t it);
      luma_result_t r;
      logic [63:0]  acc;
      if (it.mode == MODE_TABLE_WRITE) begin
        lut[it.table_index % TBL_DEPTH] = it.table_value;
        table_writes++;
        return;
      end
      r.lin_first = linearize(it.first_sample);
      if (color) begin
        r.lin_second = linearize(it.second_sample);
        r.lin_third = linearize(it.third_sample);
        acc = 64'(w_first) * 64'(r.lin_first) + 64'(w_second) * 64'(r.lin_second)
            + 64'(w_third) * 64'(r.lin_third) + 64'(ROUND_HALF);
        acc = acc >> 16;
        r.sat = (acc > 64'hFFFF);
        r.luma = r.sat ? '1 : acc[SAMPLE_W-1:0];
      end else begin
        // gray: replicate, luma is the linearized first sample itself
        r.lin_second = r.lin_first;
        r.lin_third = r.lin_first;
        r.luma = r.lin_first;
        r.sat = 1'b0;
        gray_pixels++;
      end
      if (r.sat) saturated++;
      pixels++;
      results_due = {results_due, r};
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task check_result(luma_result_t got);
      luma_result_t want;
      if (results_due.size() == 0) begin
        report($sformatf("result with nothing due (luma %0d)", got.luma));
        return;
      end
      want = results_due.pop_front();
      if (got.luma !== want.luma)
        report($sformatf("luma %0d, want %0d", got.luma, want.luma));
      if (got.lin_first !== want.lin_first)
        report($sformatf("linear_first %0d, want %0d", got.lin_first, want.lin_first));
      if (got.lin_second !== want.lin_second)
        report($sformatf("linear_second %0d, want %0d", got.lin_second, want.lin_second));
      if (got.lin_third !== want.lin_third)
        report($sformatf("linear_third %0d, want %0d", got.lin_third, want.lin_third));
      if (got.sat !== want.sat)
        report($sformatf("luma_saturated %b, want %b", got.sat, want.sat));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  pll_in_if  pix_in_bus();
  pll_out_if pix_out_bus();

  pixel_linearize_and_luma #(.TABLE_DEPTH(TBL_DEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix_in_bus),
    .pix_out  (pix_out_bus),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  luma_scoreboard luma_sb = new();

  logic                cur_table = 1'b0;
  logic                cur_wide = 1'b0;
  logic [SAMPLE_W-1:0] written_q[$];
  int                  src_pct = 0;
  int                  snk_pct = 0;
  bit                  hold_req = 1'b0;
  int                  hold_left = 0;
  int                  cycles = 0;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("pixel_linearize_and_luma: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pix_out_bus.ready <= 1'b0;
    end else begin
      pix_out_bus.ready <= ($urandom_range(99) >= snk_pct);
    end
  end

  always @(posedge clk) begin
    luma_result_t seen;
    if (!rst && pix_out_bus.valid && pix_out_bus.ready) begin
      seen.luma = pix_out_bus.luma;
      seen.lin_first = pix_out_bus.linear_first;
      seen.lin_second = pix_out_bus.linear_second;
      seen.lin_third = pix_out_bus.linear_third;
      seen.sat = pix_out_bus.luma_saturated;
      luma_sb.check_result(seen);
    end
  end

  function automatic pix_item_t pixel(logic [SAMPLE_W-1:0] f, s, t);
    pix_item_t it;
    it.mode = MODE_PIXEL;
    it.first_sample = f;
    it.second_sample = s;
    it.third_sample = t;
    it.table_index = SAMPLE_W'($urandom);
    it.table_value = SAMPLE_W'($urandom);
    return it;
  endfunction

  function automatic pix_item_t table_write(logic [SAMPLE_W-1:0] idx, value);
    pix_item_t it;
    it.mode = MODE_TABLE_WRITE;
    it.first_sample = SAMPLE_W'($urandom);
    it.second_sample = SAMPLE_W'($urandom);
    it.third_sample = SAMPLE_W'($urandom);
    it.table_index = idx;
    it.table_value = value;
    return it;
  endfunction

  // wide lookups only hit entries already loaded; narrow ones are all preloaded
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    if (cur_table && cur_wide) return written_q[$urandom_range(written_q.size() - 1)];
    return SAMPLE_W'($urandom);
  endfunction

  function automatic pix_item_t gen_item();
    logic [SAMPLE_W-1:0] idx;
    if ($urandom_range(99) < 12) begin
      idx = SAMPLE_W'($urandom);
      if ($urandom_range(3) == 0) idx[7:0] = 8'h00;
      return table_write(idx, SAMPLE_W'($urandom));
    end
    return pixel(pick_sample(), pick_sample(), pick_sample());
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    return WEIGHT_W'($urandom_range(WEIGHT_MAX));
  endfunction

  task automatic offer(input pix_item_t it);
    pix_in_bus.valid <= 1'b1;
    pix_in_bus.mode <= it.mode;
    pix_in_bus.first_sample <= it.first_sample;
    pix_in_bus.second_sample <= it.second_sample;
    pix_in_bus.third_sample <= it.third_sample;
    pix_in_bus.table_index <= it.table_index;
    pix_in_bus.table_value <= it.table_value;
    @(posedge clk);
    while (!pix_in_bus.ready) @(posedge clk);
    luma_sb.note_item(it);
    if (it.mode == MODE_TABLE_WRITE) written_q = {written_q, it.table_index};
  endtask

  task automatic sender_gap();
    while ($urandom_range(99) < src_pct) begin
      pix_in_bus.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    luma_sb.set_reg(idx, value);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic te, wide, color,
                           input logic [WEIGHT_W-1:0] wf, ws, wt);
    write_reg(REG_TABLE_ENABLE, CFG_W'(te));
    write_reg(REG_WIDE_SAMPLES, CFG_W'(wide));
    write_reg(REG_COLOR_INPUT, CFG_W'(color));
    write_reg(REG_WEIGHT_FIRST, wf);
    write_reg(REG_WEIGHT_SECOND, ws);
    write_reg(REG_WEIGHT_THIRD, wt);
    cur_table = te;
    cur_wide = wide;
  endtask

  // drop valid, wait for every due result, then let table writes retire
  task automatic settle();
    pix_in_bus.valid <= 1'b0;
    while (luma_sb.results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic run_random(input int n, src, snk, input bit hold, preload);
    int k;
    src_pct = src;
    snk_pct = snk;
    if (hold) hold_req = 1'b1;
    if (preload) begin
      // load every entry that a narrow sample can address
      for (k = 0; k < 256; k++) begin
        sender_gap();
        offer(table_write(SAMPLE_W'(k << 8), SAMPLE_W'($urandom)));
      end
    end
    for (k = 0; k < n; k++) begin
      sender_gap();
      offer(gen_item());
    end
  endtask

  initial begin
    pix_in_bus.valid <= 1'b0;
    pix_in_bus.mode <= MODE_PIXEL;
    pix_in_bus.first_sample <= '0;
    pix_in_bus.second_sample <= '0;
    pix_in_bus.third_sample <= '0;
    pix_in_bus.table_index <= '0;
    pix_in_bus.table_value <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_TABLE_ENABLE;
    cfg_data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: table off, narrow, color, default weights
    offer(pixel(16'h0000, 16'h0000, 16'h0000));
    offer(pixel(16'hFFFF, 16'hFFFF, 16'hFFFF));
    offer(pixel(16'h00FF, 16'hFF00, 16'h0080));
    offer(pixel(16'h1201, 16'h3402, 16'h5603));
    settle();

    // full-scale weights: clamp, including a sum landing exactly on 65536
    configure(1'b0, 1'b1, 1'b1, WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX);
    offer(pixel(16'hFFFF, 16'hFFFF, 16'hFFFF));
    offer(pixel(16'h0001, 16'h0001, 16'h0001));
    offer(pixel(16'h8000, 16'h0000, 16'h0000));
    offer(pixel(16'h0000, 16'h0000, 16'h0000));
    settle();

    // gray with zero weights: other samples carry noise
    configure(1'b0, 1'b1, 1'b0, '0, '0, '0);
    offer(pixel(16'hFFFF, SAMPLE_W'($urandom), SAMPLE_W'($urandom)));
    offer(pixel(16'h00A5, SAMPLE_W'($urandom), SAMPLE_W'($urandom)));
    settle();

    // table writes at both ends of the index range, then an overwrite
    offer(table_write(16'h0000, 16'hFFFF));
    offer(table_write(16'hFFFF, 16'h0000));
    offer(table_write(16'h1234, 16'h5555));
    offer(table_write(16'h1234, 16'hAAAA));
    settle();

    configure(1'b1, 1'b1, 1'b1, RST_WEIGHT_FIRST, RST_WEIGHT_SECOND, RST_WEIGHT_THIRD);
    offer(pixel(16'h0000, 16'hFFFF, 16'h1234));
    offer(table_write(16'h0000, 16'h0001));
    offer(pixel(16'h0000, 16'h0000, 16'h0000));
    offer(pixel(16'h1234, 16'h1234, 16'hFFFF));
    settle();

    configure(1'b0, 1'b0, 1'b1, RST_WEIGHT_FIRST, RST_WEIGHT_SECOND, RST_WEIGHT_THIRD);
    run_random(42, 0, 0, 1'b0, 1'b0);
    settle();
    configure(1'b1, 1'b0, 1'b1, rand_weight(), rand_weight(), rand_weight());
    run_random(42, 80, 0, 1'b0, 1'b1);
    settle();
    configure(1'b1, 1'b1, 1'b1, rand_weight(), rand_weight(), rand_weight());
    run_random(42, 0, 80, 1'b0, 1'b0);
    settle();
    configure(1'b1, 1'b1, 1'b0, rand_weight(), rand_weight(), rand_weight());
    run_random(42, 9, 9, 1'b0, 1'b0);
    settle();
    // long receiver hold-off while the sender keeps pushing
    configure(1'b0, 1'b1, 1'b1, WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX);
    run_random(42, 0, 0, 1'b1, 1'b0);
    settle();
    configure(1'b1, 1'b0, 1'b0, '0, '0, '0);
    run_random(42, 0, 80, 1'b0, 1'b0);
    settle();
    configure(1'b0, 1'b0, 1'b0, rand_weight(), rand_weight(), rand_weight());
    run_random(42, 80, 0, 1'b0, 1'b0);
    settle();
    configure(1'b1, 1'b1, 1'b1, '0, WEIGHT_MAX, rand_weight());
    run_random(42, 9, 9, 1'b0, 1'b0);
    settle();
    configure(1'b1, 1'b0, 1'b1, RST_WEIGHT_FIRST, RST_WEIGHT_SECOND, RST_WEIGHT_THIRD);
    run_random(40, 0, 0, 1'b0, 1'b0);
    settle();

    if (luma_sb.results_due.size() != 0)
      luma_sb.report($sformatf("%0d results never arrived", luma_sb.results_due.size()));
    $display("Checked %0d pixels (%0d gray, %0d with clamped luma) and %0d table loads,",
             luma_sb.pixels, luma_sb.gray_pixels, luma_sb.saturated, luma_sb.table_writes);
    $display("across default, extreme and random settings under idle, stall and hold-off.");
    if (luma_sb.mismatches == 0)
      $display("pixel_linearize_and_luma: match");
    else
      $display("pixel_linearize_and_luma: mismatch");
    $finish;
  end

endmodule
